### sv/krbv_pkg.sv
// Shared types and constants for the k-mer region bit-vector builder.
// No dependencies; imported by the front end, queue, back end, top level and testbench.
package krbv_pkg;

    localparam int DEF_KMER_LEN     = 8;
    localparam int DEF_CONTIG_LEN   = 150;
    localparam int DEF_REGION_COUNT = 3;
    localparam int DEF_SLOT_BITS    = 4;

    localparam int MAX_ADDR_W  = 23;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [2:0] PATTERN_MASK = 3'h7;

    typedef enum logic [1:0] {
        OP_BUILD = 2'd0,
        OP_PROBE = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        QK_BUILD = 2'd0,
        QK_PROBE = 2'd1,
        QK_CLEAR = 2'd2,
        QK_BAD   = 2'd3
    } entry_kind_t;

    typedef enum logic {
        BK_CLEAR = 1'b0,
        BK_RUN   = 1'b1
    } back_state_t;

    typedef struct packed {
        entry_kind_t           kind;
        logic [MAX_ADDR_W-1:0] addr;
        logic                  odd;
        logic [15:0]           index;
        logic [2:0]            mark;
        logic                  eoc;
    } queue_entry_t;

endpackage

### sv/krbv_front.sv
// Front end: accepts transactions, tracks the base window and contig position,
// and classifies each transaction into a queue entry. Uses krbv_pkg.
module krbv_front
    import krbv_pkg::*;
#(
    parameter int KMER_LEN     = DEF_KMER_LEN,
    parameter int CONTIG_LEN   = DEF_CONTIG_LEN,
    parameter int REGION_COUNT = DEF_REGION_COUNT
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [1:0]   opcode,
    input  logic [7:0]   base_char,
    input  logic [14:0]  clear_address,
    input  logic         end_of_contig,
    input  logic         clearing,
    input  logic         q_full,
    output logic         q_push,
    output queue_entry_t q_entry
);

    localparam int WIN_W       = 2 * KMER_LEN;
    localparam int RUN_W       = $clog2(KMER_LEN + 1);
    localparam int ADDR_W      = WIN_W - 1;
    localparam int REGION_SPAN = CONTIG_LEN / REGION_COUNT;

    localparam logic [9:0] SPAN1 = 10'(REGION_SPAN);
    localparam logic [9:0] SPAN2 = 10'(2 * REGION_SPAN);
    localparam logic [9:0] SPAN3 = 10'(3 * REGION_SPAN);
    localparam logic [8:0] K9    = 9'(KMER_LEN);
    localparam logic [8:0] HALF9 = 9'(KMER_LEN / 2);
    localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(KMER_LEN);
    localparam logic [MAX_ADDR_W-1:0] ADDR_MASK =
        MAX_ADDR_W'((longint'(1) << ADDR_W) - longint'(1));

    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_T = 8'h54;

    logic [WIN_W-1:0] window_reg, window_next;
    logic [7:0]       pos_reg, pos_next;
    logic [RUN_W-1:0] run_reg, run_next;

    logic             accept;
    opcode_t          op;
    logic             base_ok;
    logic [1:0]       code;
    logic [WIN_W-1:0] win_shift;
    logic [RUN_W-1:0] run_shift;
    logic [8:0]       count;
    logic [8:0]       centre;
    logic             has_kmer;
    logic             good;
    logic [2:0]       mark;

    always_comb
    begin
        case (base_char)
            CHAR_A:  begin base_ok = 1'b1; code = 2'd0; end
            CHAR_C:  begin base_ok = 1'b1; code = 2'd1; end
            CHAR_G:  begin base_ok = 1'b1; code = 2'd2; end
            CHAR_T:  begin base_ok = 1'b1; code = 2'd3; end
            default: begin base_ok = 1'b0; code = 2'd0; end
        endcase
    end

    assign in_stall  = clearing || q_full;
    assign accept    = in_valid && !in_stall;
    assign op        = opcode_t'(opcode);
    assign win_shift = {window_reg[WIN_W-3:0], code};
    assign run_shift = !base_ok ? '0 :
                       (run_reg < RUN_MAX) ? run_reg + RUN_W'(1) : RUN_MAX;
    assign count     = {1'b0, pos_reg} + 9'd1;
    assign has_kmer  = count >= K9;
    assign centre    = count - K9 + HALF9;
    assign good      = run_shift == RUN_MAX;

    always_comb
    begin
        if ({1'b0, centre} < SPAN1)
            mark = 3'b001;
        else if ({1'b0, centre} < SPAN2)
            mark = 3'b010;
        else if ({1'b0, centre} < SPAN3)
            mark = 3'b100;
        else
            mark = 3'b000;
    end

    always_comb
    begin
        window_next = window_reg;
        pos_next    = pos_reg;
        run_next    = run_reg;
        q_push      = 1'b0;
        q_entry     = '0;
        if (accept)
        begin
            case (op)
                OP_BUILD, OP_PROBE:
                begin
                    window_next = win_shift;
                    run_next    = run_shift;
                    pos_next    = count[8] ? 8'hFF : count[7:0];
                    if (end_of_contig)
                    begin
                        window_next = '0;
                        run_next    = '0;
                        pos_next    = '0;
                    end
                    q_push        = has_kmer;
                    q_entry.kind  = !good ? QK_BAD :
                                    (op == OP_BUILD) ? QK_BUILD : QK_PROBE;
                    q_entry.addr  = MAX_ADDR_W'(win_shift[WIN_W-1:1]);
                    q_entry.odd   = win_shift[0];
                    q_entry.index = good ? 16'(win_shift) : 16'd0;
                    q_entry.mark  = mark;
                    q_entry.eoc   = end_of_contig;
                end
                OP_CLEAR:
                begin
                    q_push       = 1'b1;
                    q_entry.kind = QK_CLEAR;
                    q_entry.addr = MAX_ADDR_W'(clear_address) & ADDR_MASK;
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            pos_reg    <= '0;
            run_reg    <= '0;
        end
        else
        begin
            window_reg <= window_next;
            pos_reg    <= pos_next;
            run_reg    <= run_next;
        end
    end

endmodule

### sv/krbv_queue.sv
// Short FIFO of classified entries between front and back end.
// Uses krbv_pkg for the entry type and depth.
module krbv_queue
    import krbv_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  queue_entry_t push_entry,
    output logic         full,
    input  logic         pop,
    output queue_entry_t head,
    output logic         head_valid
);

    queue_entry_t entry_reg [QUEUE_DEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full       = count_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### sv/krbv_back.sv
// Back end: slot table memory with reset sweep, read-modify-write with
// forwarding, and the result register. Uses krbv_pkg.
module krbv_back
    import krbv_pkg::*;
#(
    parameter int KMER_LEN  = DEF_KMER_LEN,
    parameter int SLOT_BITS = DEF_SLOT_BITS
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  queue_entry_t q_head,
    output logic         q_pop,
    output logic         clearing,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [15:0]  kmer_index,
    output logic [2:0]   region_mark,
    output logic [2:0]   slot_pattern,
    output logic         bad_kmer,
    output logic         contig_end
);

    localparam int ADDR_W      = 2 * KMER_LEN - 1;
    localparam int TABLE_BYTES = 1 << ADDR_W;
    localparam logic [2:0] SHIFT_HI = 3'(SLOT_BITS);

    logic [7:0] table_mem [TABLE_BYTES];

    back_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] clr_ptr_reg, clr_ptr_next;
    logic              cmd_valid_reg, cmd_valid_next;
    queue_entry_t      cmd_reg, cmd_next;
    logic [7:0]        mem_rd_reg;
    logic              fwd_reg, fwd_next;
    logic [7:0]        fwd_data_reg, fwd_data_next;
    logic              out_valid_reg, out_valid_next;
    logic [15:0]       index_reg, index_next;
    logic [2:0]        mark_reg, mark_next;
    logic [2:0]        pattern_reg, pattern_next;
    logic              bad_reg, bad_next;
    logic              eoc_reg, eoc_next;

    logic [ADDR_W-1:0] cmd_addr;
    logic [ADDR_W-1:0] head_addr;
    logic [2:0]        shift;
    logic [7:0]        cur_byte;
    logic [7:0]        mark_byte;
    logic [7:0]        new_byte;
    logic [7:0]        shifted;
    logic [2:0]        pattern;
    logic              needs_out;
    logic              out_free;
    logic              cmd_done;
    logic              do_write;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;

    assign cmd_addr  = cmd_reg.addr[ADDR_W-1:0];
    assign head_addr = q_head.addr[ADDR_W-1:0];
    assign shift     = cmd_reg.odd ? SHIFT_HI : 3'd0;
    assign cur_byte  = fwd_reg ? fwd_data_reg : mem_rd_reg;
    assign mark_byte = 8'(cmd_reg.mark) << shift;

    always_comb
    begin
        case (cmd_reg.kind)
            QK_BUILD: new_byte = cur_byte | mark_byte;
            QK_CLEAR: new_byte = 8'd0;
            default:  new_byte = cur_byte;
        endcase
    end

    assign shifted   = new_byte >> shift;
    assign pattern   = (cmd_reg.kind == QK_BAD) ? 3'd0 : (shifted[2:0] & PATTERN_MASK);
    assign needs_out = cmd_reg.kind != QK_CLEAR;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cmd_done  = cmd_valid_reg && (!needs_out || out_free);
    assign do_write  = cmd_done &&
                       (cmd_reg.kind == QK_BUILD || cmd_reg.kind == QK_CLEAR);
    assign clearing  = state_reg == BK_CLEAR;

    always_comb
    begin
        state_next     = state_reg;
        clr_ptr_next   = clr_ptr_reg;
        cmd_valid_next = cmd_valid_reg;
        cmd_next       = cmd_reg;
        fwd_next       = fwd_reg;
        fwd_data_next  = fwd_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        index_next     = index_reg;
        mark_next      = mark_reg;
        pattern_next   = pattern_reg;
        bad_next       = bad_reg;
        eoc_next       = eoc_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = cmd_addr;
        mem_wdata      = new_byte;
        case (state_reg)
            BK_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_ptr_reg;
                mem_wdata    = 8'd0;
                clr_ptr_next = clr_ptr_reg + ADDR_W'(1);
                if (clr_ptr_reg == '1)
                    state_next = BK_RUN;
            end
            BK_RUN:
            begin
                mem_we = do_write;
                if (cmd_done)
                begin
                    cmd_valid_next = 1'b0;
                    if (needs_out)
                    begin
                        out_valid_next = 1'b1;
                        index_next     = cmd_reg.index;
                        mark_next      = cmd_reg.mark;
                        pattern_next   = pattern;
                        bad_next       = cmd_reg.kind == QK_BAD;
                        eoc_next       = cmd_reg.eoc;
                    end
                end
                if (q_valid && (!cmd_valid_reg || cmd_done))
                begin
                    q_pop          = 1'b1;
                    cmd_valid_next = 1'b1;
                    cmd_next       = q_head;
                    fwd_next       = do_write && (head_addr == cmd_addr);
                    fwd_data_next  = new_byte;
                end
            end
            default:
            begin
                state_next = BK_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            table_mem[mem_waddr] <= mem_wdata;
        if (q_pop)
            mem_rd_reg <= table_mem[head_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_ptr_reg   <= '0;
            cmd_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_ptr_reg   <= clr_ptr_next;
            cmd_valid_reg <= cmd_valid_next;
            fwd_reg       <= fwd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        fwd_data_reg <= fwd_data_next;
        index_reg    <= index_next;
        mark_reg     <= mark_next;
        pattern_reg  <= pattern_next;
        bad_reg      <= bad_next;
        eoc_reg      <= eoc_next;
    end

    assign out_valid    = out_valid_reg;
    assign kmer_index   = index_reg;
    assign region_mark  = mark_reg;
    assign slot_pattern = pattern_reg;
    assign bad_kmer     = bad_reg;
    assign contig_end   = eoc_reg;

endmodule

### sv/kmer_region_bitvector_build_core.sv
// Top level of the k-mer region bit-vector builder: front end, entry queue,
// back end with the slot table. Uses krbv_pkg, krbv_front, krbv_queue, krbv_back.
//
//   channel | direction | handshake           | payload
//   input   | in        | in_valid / in_stall  | opcode, base_char, clear_address, end_of_contig
//   output  | out       | out_valid / out_stall| kmer_index, region_mark, slot_pattern,
//           |           |                      | bad_kmer, contig_end
//
// One transaction per cycle while in_stall and out_stall stay low; out_valid rises after its
// transaction has passed the queue entry, the command and table-read registers, and the
// read-modify-write into the result register. One table read and one table write per cycle
// set the rate. After reset all 2^(2*KMER_LEN-1) table bytes (32768 by default) are swept
// to zero, with in_stall high. in_stall also rises when the four-entry queue fills.
module kmer_region_bitvector_build_core
    import krbv_pkg::*;
#(
    parameter int KMER_LEN     = DEF_KMER_LEN,
    parameter int CONTIG_LEN   = DEF_CONTIG_LEN,
    parameter int REGION_COUNT = DEF_REGION_COUNT,
    parameter int SLOT_BITS    = DEF_SLOT_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [7:0]  base_char,
    input  logic [14:0] clear_address,
    input  logic        end_of_contig,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] kmer_index,
    output logic [2:0]  region_mark,
    output logic [2:0]  slot_pattern,
    output logic        bad_kmer,
    output logic        contig_end
);

    logic         clearing;
    logic         q_full;
    logic         q_push;
    queue_entry_t q_entry;
    logic         q_pop;
    queue_entry_t q_head;
    logic         q_valid;

    krbv_front #(
        .KMER_LEN     (KMER_LEN),
        .CONTIG_LEN   (CONTIG_LEN),
        .REGION_COUNT (REGION_COUNT)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .base_char     (base_char),
        .clear_address (clear_address),
        .end_of_contig (end_of_contig),
        .clearing      (clearing),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (q_entry)
    );

    krbv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .head_valid (q_valid)
    );

    krbv_back #(
        .KMER_LEN  (KMER_LEN),
        .SLOT_BITS (SLOT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .clearing     (clearing),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kmer_index   (kmer_index),
        .region_mark  (region_mark),
        .slot_pattern (slot_pattern),
        .bad_kmer     (bad_kmer),
        .contig_end   (contig_end)
    );

endmodule

### sv/krbv_checker.sv
// Port-level checks for kmer_region_bitvector_build_core, bound to the top level.
// Depends only on the top-level ports.
module krbv_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  opcode,
    input logic [7:0]  base_char,
    input logic [14:0] clear_address,
    input logic        end_of_contig,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] kmer_index,
    input logic [2:0]  region_mark,
    input logic [2:0]  slot_pattern,
    input logic        bad_kmer,
    input logic        contig_end
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(opcode) && $stable(base_char) &&
            $stable(clear_address) && $stable(end_of_contig))
        else $error("input transaction changed while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(kmer_index) && $stable(region_mark) &&
            $stable(slot_pattern) && $stable(bad_kmer) && $stable(contig_end))
        else $error("result payload changed while stalled");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_kmer |-> kmer_index == 16'd0 && slot_pattern == 3'd0)
        else $error("bad k-mer result carries index or pattern");

    a_reset_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> in_stall && !out_valid)
        else $error("input open or result shown during table sweep");

endmodule

bind kmer_region_bitvector_build_core krbv_checker u_krbv_checker (.*);

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for kmer_region_bitvector_build_core: streams contigs of build,
// probe and clear transactions and checks every result against a k-mer slot-table model.
// Depends on krbv_pkg and the RTL of the block.
module tb_top;
    import krbv_pkg::*;

    localparam int KLEN         = DEF_KMER_LEN;
    localparam int CLEN         = DEF_CONTIG_LEN;
    localparam int REGIONS      = DEF_REGION_COUNT;
    localparam int SLOT_W       = DEF_SLOT_BITS;
    localparam int TABLE_BYTES  = 1 << (2 * KLEN - 1);
    localparam int REGION_SPAN  = CLEN / REGIONS;
    localparam int TARGET_ITEMS = 1150;
    localparam int IDLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES = 32;

    localparam logic [7:0] CH_A = "A";
    localparam logic [7:0] CH_C = "C";
    localparam logic [7:0] CH_G = "G";
    localparam logic [7:0] CH_T = "T";
    localparam logic [7:0] CH_N = "N";

    typedef struct {
        opcode_t     op;
        logic [7:0]  ch;
        logic [14:0] addr;
        logic        eoc;
        bit          hold;
    } base_txn_t;

    typedef struct {
        logic [15:0] index;
        logic [2:0]  mark;
        logic [2:0]  pattern;
        logic        bad;
        logic        last;
    } slot_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode = 2'd0;
    logic [7:0]  base_char = 8'd0;
    logic [14:0] clear_address = 15'd0;
    logic        end_of_contig = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] kmer_index;
    logic [2:0]  region_mark;
    logic [2:0]  slot_pattern;
    logic        bad_kmer;
    logic        contig_end;

    base_txn_t    queued_txns[$];
    slot_result_t results_due[$];
    base_txn_t    cur_txn;
    int           errors = 0;
    int           idle_cycles = 0;
    int           item_count = 0;
    bit           hold_next = 0;
    logic [15:0]  gen_window = '0;

    logic [2*KLEN-1:0] kmer_window = '0;
    logic [7:0]        contig_pos = '0;
    int                acgt_run = 0;
    bit [7:0]          slot_bytes [0:TABLE_BYTES-1];

    int  gap_left = 0;
    bit  calm_in = 0;
    int  stall_left = 0;
    bit  calm_out = 0;

    kmer_region_bitvector_build_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .base_char     (base_char),
        .clear_address (clear_address),
        .end_of_contig (end_of_contig),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kmer_index    (kmer_index),
        .region_mark   (region_mark),
        .slot_pattern  (slot_pattern),
        .bad_kmer      (bad_kmer),
        .contig_end    (contig_end)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [7:0] acgt(input int code);
        case (code)
            0: return CH_A;
            1: return CH_C;
            2: return CH_G;
            default: return CH_T;
        endcase
    endfunction

    // Advance the slot-table model by one transaction; return 1 when it yields a result.
    function automatic bit predict_slot(input base_txn_t t, output slot_result_t r);
        logic [1:0]  code;
        bit          known;
        int          count;
        int          region;
        int          shift;
        logic [2:0]  mark;
        logic [15:0] idx;
        bit          made;
        made = 0;
        r = '{default: '0};
        if (t.op == OP_CLEAR)
        begin
            slot_bytes[int'(t.addr) & (TABLE_BYTES - 1)] = '0;
            return 0;
        end
        if (t.op == OP_NONE)
            return 0;
        known = 1;
        case (t.ch)
            CH_A: code = 2'd0;
            CH_C: code = 2'd1;
            CH_G: code = 2'd2;
            CH_T: code = 2'd3;
            default:
            begin
                code = 2'd0;
                known = 0;
            end
        endcase
        kmer_window = (kmer_window << 2) | code;
        if (known)
            acgt_run = (acgt_run < KLEN) ? acgt_run + 1 : KLEN;
        else
            acgt_run = 0;
        count = int'(contig_pos) + 1;
        if (count >= KLEN)
        begin
            region = (count - KLEN + KLEN / 2) / REGION_SPAN;
            mark = (region < 3) ? 3'((1 << region) & 7) : 3'd0;
            r.mark = mark;
            r.index = '0;
            r.pattern = '0;
            if (acgt_run >= KLEN)
            begin
                idx = 16'(kmer_window);
                shift = idx[0] ? SLOT_W : 0;
                if (t.op == OP_BUILD)
                    slot_bytes[idx >> 1] = slot_bytes[idx >> 1] | (8'(mark) << shift);
                r.index = idx;
                r.pattern = 3'((slot_bytes[idx >> 1] >> shift) & 8'(PATTERN_MASK));
            end
            r.bad = (acgt_run >= KLEN) ? 1'b0 : 1'b1;
            r.last = t.eoc;
            made = 1;
        end
        contig_pos = (count > 255) ? 8'd255 : 8'(count);
        if (t.eoc)
        begin
            kmer_window = '0;
            contig_pos = '0;
            acgt_run = 0;
        end
        return made;
    endfunction

    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
        end
    endfunction

    task automatic add_txn(input opcode_t op, input logic [7:0] ch, input logic [14:0] addr,
                           input logic eoc);
        base_txn_t t;
        t.op = op;
        t.ch = ch;
        t.addr = addr;
        t.eoc = eoc;
        t.hold = hold_next;
        hold_next = 0;
        queued_txns.push_back(t);
        if (op != OP_NONE)
            item_count++;
    endtask

    task automatic add_base(input opcode_t op, input logic [7:0] ch, input logic eoc);
        logic [1:0] code;
        code = (ch == CH_C) ? 2'd1 : (ch == CH_G) ? 2'd2 : (ch == CH_T) ? 2'd3 : 2'd0;
        gen_window = eoc ? '0 : ((gen_window << 2) | code);
        add_txn(op, ch, 15'($urandom), eoc);
    endtask

    task automatic add_clear(input logic [14:0] addr);
        add_txn(OP_CLEAR, 8'($urandom), addr, 1'($urandom));
    endtask

    // Driver: present queued transactions, model each one as it is accepted.
    always @(posedge clk)
    begin
        slot_result_t r;
        bit busy;
        if (rst_n)
        begin
            busy = in_valid;
            if (in_valid && !in_stall)
            begin
                if (predict_slot(cur_txn, r))
                    results_due.push_back(r);
                busy = 0;
            end
            if (!busy)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (queued_txns.size() > 0
                         && !(queued_txns[0].hold && results_due.size() > 0))
                begin
                    cur_txn = queued_txns.pop_front();
                    opcode <= cur_txn.op;
                    base_char <= cur_txn.ch;
                    clear_address <= cur_txn.addr;
                    end_of_contig <= cur_txn.eoc;
                    busy = 1;
                    if ($urandom_range(0, 39) == 0)
                        calm_in = !calm_in;
                    gap_left = calm_in ? 0 : $urandom_range(0, 5);
                end
            end
            in_valid <= busy;
        end
    end

    // Monitor: compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        slot_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with none expected, expected none actual index %0h",
                             $time, kmer_index);
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("kmer_index", want.index, kmer_index);
                    check_field("region_mark", want.mark, region_mark);
                    check_field("slot_pattern", want.pattern, slot_pattern);
                    check_field("bad_kmer", want.bad, bad_kmer);
                    check_field("contig_end", want.last, contig_end);
                end
                if ($urandom_range(0, 29) == 0)
                    calm_out = !calm_out;
                stall_left = calm_out ? 0 : $urandom_range(0, 5);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        logic [7:0] ch;
        logic [7:0] replay[$];
        logic [7:0] fresh[$];
        int         pick;
        int         clen;
        int         style;
        int         roll;
        int         pair_lo;
        int         pair_hi;
        bit         mid_hold_done;
        opcode_t    op;
        mid_hold_done = 0;

        for (int i = 0; i < KLEN; i++)
            add_base(OP_BUILD, CH_A, 1'b0);
        add_clear(15'd0);
        add_base(OP_PROBE, CH_A, 1'b1);
        add_base(OP_BUILD, CH_G, 1'b1);
        for (int i = 0; i < KLEN; i++)
            add_base(OP_BUILD, CH_T, 1'b0);
        add_txn(OP_NONE, 8'hFF, 15'h7FFF, 1'b1);
        add_base(OP_PROBE, 8'h00, 1'b0);
        add_base(OP_BUILD, 8'hFF, 1'b1);
        hold_next = 1;
        add_clear(15'h7FFF);

        while (item_count < TARGET_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                clen = $urandom_range(KLEN, 40);
            else if (pick < 88)
                clen = $urandom_range(1, KLEN - 1);
            else
                clen = $urandom_range(150, 280);
            style = $urandom_range(0, 3);
            if (style == 3 && replay.size() == 0)
                style = 0;
            if (style == 3)
                clen = replay.size();
            pair_lo = $urandom_range(0, 3);
            pair_hi = $urandom_range(0, 3);
            for (int i = 0; i < clen; i++)
            begin
                if (!mid_hold_done && item_count >= TARGET_ITEMS / 2)
                begin
                    hold_next = 1;
                    mid_hold_done = 1;
                end
                if ($urandom_range(0, 99) < 4)
                    add_clear($urandom_range(0, 1) ? 15'($urandom) : 15'(gen_window >> 1));
                if ($urandom_range(0, 99) < 2)
                    add_txn(OP_NONE, 8'($urandom), 15'($urandom), 1'($urandom));
                if (style == 3)
                    ch = replay[i];
                else
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 3)
                        ch = 8'($urandom);
                    else if (roll < 5)
                        ch = CH_N;
                    else if (style == 2)
                        ch = acgt($urandom_range(0, 1) ? pair_lo : pair_hi);
                    else
                        ch = acgt($urandom_range(0, 3));
                    fresh.push_back(ch);
                end
                op = ($urandom_range(0, 99) < ((style == 3) ? 70 : 40)) ? OP_PROBE : OP_BUILD;
                add_base(op, ch, i == clen - 1);
            end
            if (style != 3)
                replay = fresh;
            fresh.delete();
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        while (!(queued_txns.size() == 0 && !in_valid && results_due.size() == 0)
               && idle_cycles < IDLE_LIMIT)
            @(negedge clk);
        if (idle_cycles < IDLE_LIMIT)
            repeat (DRAIN_CYCLES) @(negedge clk);
        if (results_due.size() != 0)
        begin
            errors++;
            $display("%0t: results outstanding, expected 0 actual %0d", $time,
                     results_due.size());
        end
        if (idle_cycles >= IDLE_LIMIT || errors != 0)
            $display("DONE: errors detected");
        else
            $display("DONE: 0 errors");
        $finish;
    end

endmodule

### kmer_region_bitvector_build_core.f
sv/krbv_pkg.sv
sv/krbv_front.sv
sv/krbv_queue.sv
sv/krbv_back.sv
sv/kmer_region_bitvector_build_core.sv
sv/krbv_checker.sv
sim/tb_top.sv
